// ----- rtl/text_console_cursor_engine_defines.svh -----
// Assertion macros shared by the console engine RTL.
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define TCCE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define TCCE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/tcce_pkg.sv -----
// Shared types and constants for the text console cursor engine.
package tcce_pkg;

    localparam int REQ_W        = 3;
    localparam int CHAR_W       = 8;
    localparam int POS_IN_W     = 8;
    localparam int CELL_W       = 16;
    localparam int CURSOR_COL_W = 7;
    localparam int CURSOR_ROW_W = 5;

    localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0720;

    // Control characters handled by put char
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUT   = 3'd0,
        REQ_READ  = 3'd1,
        REQ_SET   = 3'd2,
        REQ_BLANK = 3'd3,
        REQ_CLEAR = 3'd4
    } t_req;

    // Controller to datapath
    typedef struct packed {
        logic load;         // latch the accepted transaction
        logic exec;         // decode and apply the request
        logic rd_capture;   // take read data from the store
        logic clear_sweep;  // write blanks over the whole store
        logic scroll_sweep; // copy rows up, blank the bottom row
        logic load_out;     // fill the result register
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic is_read;
        logic is_clear;
        logic need_scroll;
        logic clear_last;
        logic scroll_last;
    } t_dp_stat;

endpackage

// ----- rtl/tcce_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module tcce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/tcce_ctrl.sv -----
// Sequencing state machine for the console engine.
`include "text_console_cursor_engine_defines.svh"

module tcce_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output tcce_pkg::t_dp_cmd  o_cmd,
    input  tcce_pkg::t_dp_stat i_stat
);
    import tcce_pkg::*;

    typedef enum logic [6:0] {
        S_INIT   = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_EXEC   = 7'b0000100,
        S_RDWAIT = 7'b0001000,
        S_SCROLL = 7'b0010000,
        S_CLEAR  = 7'b0100000,
        S_FINISH = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_INIT: begin
                o_cmd.clear_sweep = 1'b1;
                if (i_stat.clear_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                priority if (i_stat.is_clear)    n_state = S_CLEAR;
                else if     (i_stat.is_read)     n_state = S_RDWAIT;
                else if     (i_stat.need_scroll) n_state = S_SCROLL;
                else                             n_state = S_FINISH;
            end
            S_RDWAIT: begin
                o_cmd.rd_capture = 1'b1;
                n_state          = S_FINISH;
            end
            S_SCROLL: begin
                o_cmd.scroll_sweep = 1'b1;
                if (i_stat.scroll_last) n_state = S_FINISH;
            end
            S_CLEAR: begin
                o_cmd.clear_sweep = 1'b1;
                if (i_stat.clear_last) n_state = S_FINISH;
            end
            S_FINISH: begin
                // wait for room in the result register
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_INIT;
        endcase
    end

    // Result register occupancy
    always_comb begin
        priority if (o_cmd.load_out)           n_out_valid = 1'b1;
        else if (r_out_valid && !i_out_stall)  n_out_valid = 1'b0;
        else                                   n_out_valid = r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    `TCCE_ASSERT_NXT(a_accept_busy, i_in_valid && !o_in_stall, o_in_stall,
        "input taken but engine not busy next cycle")
    `TCCE_ASSERT_IMP(a_out_from_finish, $rose(r_out_valid), $past(r_state == S_FINISH),
        "result appeared outside the finish step")
    `TCCE_ASSERT_NXT(a_finish_holds, (r_state == S_FINISH) && r_out_valid && i_out_stall,
        r_state == S_FINISH, "result register overwritten while full")

endmodule

// ----- rtl/tcce_dp.sv -----
// Cursor, request registers, screen store and sweep logic of the console engine.
`include "text_console_cursor_engine_defines.svh"

module tcce_dp #(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STOP = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  tcce_pkg::t_dp_cmd                   i_cmd,
    output tcce_pkg::t_dp_stat                  o_stat,
    input  logic [tcce_pkg::REQ_W-1:0]          i_req_type,
    input  logic [tcce_pkg::CHAR_W-1:0]         i_char_code,
    input  logic [tcce_pkg::CHAR_W-1:0]         i_attr,
    input  logic signed [tcce_pkg::POS_IN_W-1:0] i_col,
    input  logic signed [tcce_pkg::POS_IN_W-1:0] i_row,
    output logic [tcce_pkg::CURSOR_COL_W-1:0]   o_cursor_col,
    output logic [tcce_pkg::CURSOR_ROW_W-1:0]   o_cursor_row,
    output logic [tcce_pkg::CHAR_W-1:0]         o_cell_char,
    output logic [tcce_pkg::CHAR_W-1:0]         o_cell_attr
);
    import tcce_pkg::*;

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int CX_W       = $clog2(COLUMNS);
    localparam int RW         = $clog2(ROWS);
    localparam int AW         = $clog2(CELL_COUNT);
    localparam int PW         = $clog2(CELL_COUNT + 1);

    // Latched transaction
    t_req              r_req;
    logic [CHAR_W-1:0] r_char;
    logic [CHAR_W-1:0] r_attr;
    logic [CX_W-1:0]   r_arg_x;
    logic [RW-1:0]     r_arg_y;

    // Cursor
    logic [CX_W-1:0] r_cur_x, n_cur_x;
    logic [RW-1:0]   r_cur_y, n_cur_y;
    logic [AW-1:0]   r_cur_addr;

    // Sweep pointer and delayed scroll write
    logic [PW-1:0]   r_ptr;
    logic            r_wr_pend;
    logic            r_wr_copy;
    logic [AW-1:0]   r_wr_addr;

    logic [CELL_W-1:0] r_cell;
    logic [CURSOR_COL_W-1:0] r_out_col;
    logic [CURSOR_ROW_W-1:0] r_out_row;
    logic [CHAR_W-1:0]       r_out_char;
    logic [CHAR_W-1:0]       r_out_attr;

    // Store port signals
    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [CELL_W-1:0] w_wdata;
    logic [AW-1:0]     w_raddr;
    logic [CELL_W-1:0] w_rdata;

    logic [CX_W-1:0]   w_clamp_x;
    logic [RW-1:0]     w_clamp_y;
    logic              w_last_row;
    logic              w_line_feed;
    logic              w_need_scroll;
    logic              w_exec_we;
    logic [CELL_W-1:0] w_exec_wdata;
    logic              w_issue;
    logic              w_copy;
    logic [AW-1:0]     w_scroll_raddr;
    logic [AW-1:0]     w_read_addr;

    // Tab stop table: next stop per column and whether it runs off the line
    logic [CX_W-1:0] w_tab_pos  [COLUMNS];
    logic            w_tab_wrap [COLUMNS];

    for (genvar g = 0; g < COLUMNS; g++) begin : g_tab
        localparam int TabNext = ((g / TAB_STOP) + 1) * TAB_STOP;
        assign w_tab_pos[g]  = CX_W'(TabNext);
        assign w_tab_wrap[g] = (TabNext >= COLUMNS);
    end

    // Clamp signed coordinates into the screen
    always_comb begin
        priority if (i_col[POS_IN_W-1])                w_clamp_x = '0;
        else if (9'(i_col[6:0]) >= 9'(COLUMNS))         w_clamp_x = CX_W'(COLUMNS - 1);
        else                                            w_clamp_x = CX_W'(i_col[6:0]);
        priority if (i_row[POS_IN_W-1])                w_clamp_y = '0;
        else if (9'(i_row[6:0]) >= 9'(ROWS))            w_clamp_y = RW'(ROWS - 1);
        else                                            w_clamp_y = RW'(i_row[6:0]);
    end

    assign w_last_row  = (r_cur_y == RW'(ROWS - 1));
    assign w_read_addr = AW'(r_arg_y * COLUMNS) + AW'(r_arg_x);

    // Request decode and cursor movement
    always_comb begin
        n_cur_x       = r_cur_x;
        n_cur_y       = r_cur_y;
        w_line_feed   = 1'b0;
        w_need_scroll = 1'b0;
        w_exec_we     = 1'b0;
        w_exec_wdata  = BLANK_CELL;
        if (i_cmd.exec) begin
            unique case (r_req)
                REQ_PUT: begin
                    priority if (r_char == CH_NEWLINE) begin
                        w_line_feed = 1'b1;
                    end else if (r_char == CH_RETURN) begin
                        n_cur_x = '0;
                    end else if (r_char == CH_BACKSPACE) begin
                        if (r_cur_x != '0) n_cur_x = r_cur_x - 1'b1;
                    end else if (r_char == CH_TAB) begin
                        if (w_tab_wrap[r_cur_x]) w_line_feed = 1'b1;
                        else                     n_cur_x = w_tab_pos[r_cur_x];
                    end else begin
                        w_exec_we    = 1'b1;
                        w_exec_wdata = {r_attr, r_char};
                        if (r_cur_x == CX_W'(COLUMNS - 1)) w_line_feed = 1'b1;
                        else                               n_cur_x = r_cur_x + 1'b1;
                    end
                end
                REQ_SET: begin
                    n_cur_x = r_arg_x;
                    n_cur_y = r_arg_y;
                end
                REQ_BLANK: begin
                    w_exec_we = 1'b1;
                end
                REQ_CLEAR: begin
                    n_cur_x = '0;
                    n_cur_y = '0;
                end
                default: ;
            endcase
            // next line, or scroll when leaving the bottom row
            if (w_line_feed) begin
                n_cur_x = '0;
                if (w_last_row) w_need_scroll = 1'b1;
                else            n_cur_y = r_cur_y + 1'b1;
            end
        end
    end

    // Scroll sweep: read one row below, write here in the following cycle
    assign w_issue        = i_cmd.scroll_sweep && (r_ptr < PW'(CELL_COUNT));
    assign w_copy         = (r_ptr < PW'(CELL_COUNT - COLUMNS));
    assign w_scroll_raddr = w_copy ? AW'(r_ptr + PW'(COLUMNS)) : r_ptr[AW-1:0];

    // Store port selection
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_cur_addr;
        w_wdata = w_exec_wdata;
        priority if (i_cmd.clear_sweep) begin
            w_we    = 1'b1;
            w_waddr = r_ptr[AW-1:0];
            w_wdata = BLANK_CELL;
        end else if (i_cmd.scroll_sweep) begin
            w_we    = r_wr_pend;
            w_waddr = r_wr_addr;
            w_wdata = r_wr_copy ? w_rdata : BLANK_CELL;
        end else begin
            w_we = w_exec_we;
        end
        priority if (i_cmd.scroll_sweep) w_raddr = w_scroll_raddr;
        else                             w_raddr = w_read_addr;
    end

    tcce_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_COUNT)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x   <= '0;
            r_cur_y   <= '0;
            r_ptr     <= '0;
            r_wr_pend <= 1'b0;
        end else begin
            r_cur_x   <= n_cur_x;
            r_cur_y   <= n_cur_y;
            r_wr_pend <= w_issue;
            if (i_cmd.clear_sweep || w_issue) r_ptr <= r_ptr + 1'b1;
            else if (!i_cmd.scroll_sweep)     r_ptr <= '0;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cur_addr <= AW'(r_cur_y * COLUMNS) + AW'(r_cur_x);
        r_wr_addr  <= r_ptr[AW-1:0];
        r_wr_copy  <= w_copy;
        if (i_cmd.load) begin
            r_req   <= t_req'(i_req_type);
            r_char  <= i_char_code;
            r_attr  <= i_attr;
            r_arg_x <= w_clamp_x;
            r_arg_y <= w_clamp_y;
            r_cell  <= '0;
        end else if (i_cmd.rd_capture) begin
            r_cell  <= w_rdata;
        end
        if (i_cmd.load_out) begin
            r_out_col  <= CURSOR_COL_W'(r_cur_x);
            r_out_row  <= CURSOR_ROW_W'(r_cur_y);
            r_out_char <= r_cell[CHAR_W-1:0];
            r_out_attr <= r_cell[CELL_W-1:CHAR_W];
        end
    end

    assign o_stat.is_read     = (r_req == REQ_READ);
    assign o_stat.is_clear    = (r_req == REQ_CLEAR);
    assign o_stat.need_scroll = w_need_scroll;
    assign o_stat.clear_last  = (r_ptr == PW'(CELL_COUNT - 1));
    assign o_stat.scroll_last = r_wr_pend && (r_wr_addr == AW'(CELL_COUNT - 1));

    assign o_cursor_col = r_out_col;
    assign o_cursor_row = r_out_row;
    assign o_cell_char  = r_out_char;
    assign o_cell_attr  = r_out_attr;

    `TCCE_ASSERT_NXT(a_cursor_range, 1'b1,
        (32'(r_cur_x) < COLUMNS) && (32'(r_cur_y) < ROWS), "cursor left the screen")
    `TCCE_ASSERT_IMP(a_read_no_write, i_cmd.exec && (r_req == REQ_READ), !w_we,
        "store written while serving a cell read")

endmodule

// ----- rtl/text_console_cursor_engine.sv -----
// Top level of the text console cursor engine.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+---------------------------------------
//  request | in        | i_in_valid / o_in_stall    | req_type, char_code, attr, col, row
//  result  | out       | o_out_valid / i_out_stall  | cursor_col, cursor_row, cell_char/attr
//
//  Put char, set cursor, blank cell and unused codes pass the exec and finish steps; read
//  cell adds a read-wait step. Scroll and clear screen add a sweep step that walks the
//  screen RAM (one write port, one read port) one cell per cycle.
//  After reset a clearing pass over all COLUMNS*ROWS cells runs with o_in_stall high.
//  A stalled result holds the engine in its finish step; the next request is still
//  taken while the previous result waits in the output register.
module text_console_cursor_engine #(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STOP = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [tcce_pkg::REQ_W-1:0]           i_req_type,
    input  logic [tcce_pkg::CHAR_W-1:0]          i_char_code,
    input  logic [tcce_pkg::CHAR_W-1:0]          i_attr,
    input  logic signed [tcce_pkg::POS_IN_W-1:0] i_col,
    input  logic signed [tcce_pkg::POS_IN_W-1:0] i_row,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [tcce_pkg::CURSOR_COL_W-1:0]    o_cursor_col,
    output logic [tcce_pkg::CURSOR_ROW_W-1:0]    o_cursor_row,
    output logic [tcce_pkg::CHAR_W-1:0]          o_cell_char,
    output logic [tcce_pkg::CHAR_W-1:0]          o_cell_attr
);
    import tcce_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    tcce_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    tcce_dp #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_STOP (TAB_STOP)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_req_type   (i_req_type),
        .i_char_code  (i_char_code),
        .i_attr       (i_attr),
        .i_col        (i_col),
        .i_row        (i_row),
        .o_cursor_col (o_cursor_col),
        .o_cursor_row (o_cursor_row),
        .o_cell_char  (o_cell_char),
        .o_cell_attr  (o_cell_attr)
    );

endmodule

// ----- test/text_console_cursor_engine_test.sv -----
// Self-checking testbench for the text console cursor engine: random and directed requests.
module text_console_cursor_engine_test;
    import tcce_pkg::*;

    localparam int SCREEN_COLS = 80;
    localparam int SCREEN_ROWS = 25;
    localparam int TAB_WIDTH   = 8;
    localparam int CELL_TOTAL  = SCREEN_COLS * SCREEN_ROWS;
    localparam int RANDOM_REQS = 400;
    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int HOLD_AFTER  = 60;   // transactions accepted before the long output hold
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_AT    = 200;  // random transaction that waits for an empty pipe

    // request codes the block does not decode
    localparam logic [REQ_W-1:0] REQ_UNUSED_LO = 3'd5;
    localparam logic [REQ_W-1:0] REQ_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic [REQ_W-1:0]  kind;
        logic [CHAR_W-1:0] chr;
        logic [CHAR_W-1:0] attr;
        logic [7:0]        col;
        logic [7:0]        row;
        logic              drain;   // hold until all reports are back
    } t_console_req;

    typedef struct packed {
        logic [CURSOR_COL_W-1:0] ccol;
        logic [CURSOR_ROW_W-1:0] crow;
        logic [CHAR_W-1:0]       chr;
        logic [CHAR_W-1:0]       attr;
    } t_cursor_report;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_stall;
    logic [REQ_W-1:0]            i_req_type = '0;
    logic [CHAR_W-1:0]           i_char_code = '0;
    logic [CHAR_W-1:0]           i_attr = '0;
    logic signed [POS_IN_W-1:0]  i_col = '0;
    logic signed [POS_IN_W-1:0]  i_row = '0;
    logic                        o_out_valid;
    logic                        i_out_stall = 1'b0;
    logic [CURSOR_COL_W-1:0]     o_cursor_col;
    logic [CURSOR_ROW_W-1:0]     o_cursor_row;
    logic [CHAR_W-1:0]           o_cell_char;
    logic [CHAR_W-1:0]           o_cell_attr;

    text_console_cursor_engine #(
        .COLUMNS (SCREEN_COLS),
        .ROWS    (SCREEN_ROWS),
        .TAB_STOP(TAB_WIDTH)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_req_type  (i_req_type),
        .i_char_code (i_char_code),
        .i_attr      (i_attr),
        .i_col       (i_col),
        .i_row       (i_row),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cursor_col(o_cursor_col),
        .o_cursor_row(o_cursor_row),
        .o_cell_char (o_cell_char),
        .o_cell_attr (o_cell_attr)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // ---------------------------------------------------------------
    // Screen and cursor predictor
    // ---------------------------------------------------------------
    logic [CELL_W-1:0] screen_image [CELL_TOTAL];
    int cur_x, cur_y;
    int req_tally [8];
    int scroll_tally;

    function automatic int clamp_pos(input int v, input int lim);
        if (v < 0) return 0;
        if (v >= lim) return lim - 1;
        return v;
    endfunction

    task automatic scroll_screen();
        for (int i = 0; i < CELL_TOTAL - SCREEN_COLS; i++)
            screen_image[i] = screen_image[i + SCREEN_COLS];
        for (int i = CELL_TOTAL - SCREEN_COLS; i < CELL_TOTAL; i++)
            screen_image[i] = BLANK_CELL;
        cur_y = SCREEN_ROWS - 1;
        scroll_tally++;
    endtask

    task automatic advance_line();
        cur_x = 0;
        cur_y++;
        if (cur_y >= SCREEN_ROWS) scroll_screen();
    endtask

    task automatic apply_console_req(input t_console_req r, output t_cursor_report rep);
        int cx, cy, nx;
        rep = '0;
        req_tally[r.kind]++;
        case (r.kind)
            REQ_PUT: begin
                if (r.chr == CH_NEWLINE) begin
                    advance_line();
                end else if (r.chr == CH_RETURN) begin
                    cur_x = 0;
                end else if (r.chr == CH_BACKSPACE) begin
                    if (cur_x > 0) cur_x--;
                end else if (r.chr == CH_TAB) begin
                    nx = (cur_x / TAB_WIDTH + 1) * TAB_WIDTH;
                    if (nx >= SCREEN_COLS) advance_line();
                    else cur_x = nx;
                end else begin
                    screen_image[cur_y * SCREEN_COLS + cur_x] = {r.attr, r.chr};
                    cur_x++;
                    if (cur_x >= SCREEN_COLS) advance_line();
                end
            end
            REQ_READ: begin
                cx = clamp_pos(int'($signed(r.col)), SCREEN_COLS);
                cy = clamp_pos(int'($signed(r.row)), SCREEN_ROWS);
                rep.chr  = screen_image[cy * SCREEN_COLS + cx][7:0];
                rep.attr = screen_image[cy * SCREEN_COLS + cx][15:8];
            end
            REQ_SET: begin
                cur_x = clamp_pos(int'($signed(r.col)), SCREEN_COLS);
                cur_y = clamp_pos(int'($signed(r.row)), SCREEN_ROWS);
            end
            REQ_BLANK: screen_image[cur_y * SCREEN_COLS + cur_x] = BLANK_CELL;
            REQ_CLEAR: begin
                for (int i = 0; i < CELL_TOTAL; i++) screen_image[i] = BLANK_CELL;
                cur_x = 0;
                cur_y = 0;
            end
            default: ;
        endcase
        rep.ccol = cur_x[CURSOR_COL_W-1:0];
        rep.crow = cur_y[CURSOR_ROW_W-1:0];
    endtask

    // ---------------------------------------------------------------
    // Stimulus store
    // ---------------------------------------------------------------
    t_console_req   pending_reqs [$];
    t_cursor_report awaited_reports [$];

    task automatic push_req(input logic [REQ_W-1:0] kind, input int chr, input int attr,
                            input int col, input int row, input bit drain = 1'b0);
        t_console_req r;
        r.kind  = kind;
        r.chr   = chr[7:0];
        r.attr  = attr[7:0];
        r.col   = col[7:0];
        r.row   = row[7:0];
        r.drain = drain;
        pending_reqs.push_back(r);
    endtask

    // mostly plain text, now and then any byte at all
    function automatic int rand_glyph();
        if ($urandom_range(0, 4) == 0) return $urandom_range(0, 255);
        return $urandom_range(8'h20, 8'h7E);
    endfunction

    // idle length: mostly none or short, a few long
    function automatic int pick_idle();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 85) return $urandom_range(1, 3);
        if (p < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic build_random(input int count);
        int made, seg, len, attr;
        made = 0;
        while (made < count) begin
            seg = $urandom_range(0, 99);
            if (seg < 45) begin
                // a run of text in one color, ended by a line control
                len  = $urandom_range(2, 30);
                attr = $urandom_range(0, 255);
                for (int i = 0; i < len; i++)
                    push_req(REQ_PUT, rand_glyph(), attr, $urandom, $urandom);
                case ($urandom_range(0, 3))
                    0: push_req(REQ_PUT, int'(CH_RETURN), $urandom, $urandom, $urandom);
                    1: push_req(REQ_PUT, int'(CH_TAB), $urandom, $urandom, $urandom);
                    default: push_req(REQ_PUT, int'(CH_NEWLINE), $urandom, $urandom, $urandom);
                endcase
                made += len + 1;
            end else if (seg < 60) begin
                // cursor jump, often near the bottom right corner
                if ($urandom_range(0, 1))
                    push_req(REQ_SET, 0, 0, $urandom_range(SCREEN_COLS - 10, SCREEN_COLS - 1),
                             $urandom_range(SCREEN_ROWS - 4, SCREEN_ROWS - 1));
                else
                    push_req(REQ_SET, $urandom, $urandom, $urandom, $urandom);
                made++;
            end else if (seg < 78) begin
                len = $urandom_range(1, 3);
                for (int i = 0; i < len; i++) begin
                    if ($urandom_range(0, 2) == 0)
                        push_req(REQ_READ, $urandom, $urandom, $urandom, $urandom);
                    else
                        push_req(REQ_READ, $urandom, $urandom, $urandom_range(0, 15),
                                 $urandom_range(SCREEN_ROWS - 6, SCREEN_ROWS - 1));
                end
                made += len;
            end else if (seg < 86) begin
                push_req(REQ_PUT, int'(CH_BACKSPACE), $urandom, $urandom, $urandom);
                push_req(REQ_BLANK, $urandom, $urandom, $urandom, $urandom);
                made += 2;
            end else if (seg < 92) begin
                push_req(REQ_PUT, int'(CH_TAB), $urandom, $urandom, $urandom);
                made++;
            end else if (seg < 94) begin
                push_req(REQ_CLEAR, $urandom, $urandom, $urandom, $urandom);
                made++;
            end else if (seg < 97) begin
                push_req(REQ_W'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI)), $urandom,
                         $urandom, $urandom, $urandom);
                made++;
            end else begin
                // noise: any request code with any content
                push_req(REQ_W'($urandom_range(REQ_PUT, REQ_UNUSED_HI)), $urandom, $urandom,
                         $urandom, $urandom);
                made++;
            end
        end
        if (pending_reqs.size() > DRAIN_AT) pending_reqs[DRAIN_AT].drain = 1'b1;
    endtask

    // ---------------------------------------------------------------
    // Request driver
    // ---------------------------------------------------------------
    t_console_req offered_req = '0;
    int send_gap = 0;
    int send_quiet = 0;
    int accepted_total = 0;

    always @(posedge i_clk) begin : req_driver
        t_cursor_report rep;
        logic next_valid;
        next_valid = i_in_valid;
        if (!i_rst_n) begin
            next_valid = 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (i_in_valid) begin
                apply_console_req(offered_req, rep);
                awaited_reports.push_back(rep);
                accepted_total++;
            end
            next_valid = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
            end else if (pending_reqs.size() > 0 &&
                         (!pending_reqs[0].drain || awaited_reports.size() == 0)) begin
                offered_req = pending_reqs.pop_front();
                i_req_type  <= offered_req.kind;
                i_char_code <= offered_req.chr;
                i_attr      <= offered_req.attr;
                i_col       <= offered_req.col;
                i_row       <= offered_req.row;
                next_valid  = 1'b1;
                // pick the idle time that follows this transaction
                if (send_quiet > 0) begin
                    send_quiet--;
                end else begin
                    send_gap = pick_idle();
                    if ($urandom_range(0, 29) == 0) send_quiet = $urandom_range(20, 40);
                end
            end
        end
        i_in_valid <= next_valid;
    end

    // ---------------------------------------------------------------
    // Output stall generator, with one long hold to back up the block
    // ---------------------------------------------------------------
    int stall_left = 0;
    int calm_left = 0;
    int hold_left = 0;
    int seen_accepts = 0;
    bit hold_done = 1'b0;

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) seen_accepts++;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (!hold_done && seen_accepts >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            i_out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (calm_left > 0) begin
            calm_left--;
            i_out_stall <= 1'b0;
        end else begin
            stall_left = pick_idle();
            calm_left  = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(0, 4);
            i_out_stall <= 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // Result monitor
    // ---------------------------------------------------------------
    int mismatch_count = 0;
    int checked_count = 0;

    always @(posedge i_clk) begin : report_monitor
        t_cursor_report got, want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = {o_cursor_col, o_cursor_row, o_cell_char, o_cell_attr};
            if (awaited_reports.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: cursor %0d,%0d cell %h/%h",
                             got.ccol, got.crow, got.chr, got.attr);
            end else begin
                want = awaited_reports.pop_front();
                checked_count++;
                if (got.ccol !== want.ccol || got.crow !== want.crow ||
                    got.chr !== want.chr || got.attr !== want.attr) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result %0d mismatch: cursor %0d,%0d cell %h/%h, %s %0d,%0d %h/%h",
                                 checked_count, got.ccol, got.crow, got.chr, got.attr,
                                 "expected", want.ccol, want.crow, want.chr, want.attr);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Watchdog
    // ---------------------------------------------------------------
    int cycle_count = 0;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d reports outstanding",
                     cycle_count, awaited_reports.size());
            $display("FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Sequence: directed cases, random traffic, drain, verdict
    // ---------------------------------------------------------------
    initial begin
        for (int i = 0; i < CELL_TOTAL; i++) screen_image[i] = BLANK_CELL;
        cur_x = 0;
        cur_y = 0;
        scroll_tally = 0;
        foreach (req_tally[i]) req_tally[i] = 0;

        // reads clamped at both ends of the signed range
        push_req(REQ_READ, 0, 0, -128, -128);
        push_req(REQ_READ, 255, 255, 127, 127);
        // extremes of character and attribute, backspace does not erase
        push_req(REQ_PUT, 'h41, 'h1F, 0, 0);
        push_req(REQ_PUT, 255, 255, 0, 0);
        push_req(REQ_PUT, 0, 0, 0, 0);
        push_req(REQ_PUT, int'(CH_BACKSPACE), 0, 0, 0);
        push_req(REQ_READ, 0, 0, 1, 0);
        push_req(REQ_READ, 0, 0, 2, 0);
        // tab, return, backspace at column zero
        push_req(REQ_PUT, int'(CH_TAB), 0, 0, 0);
        push_req(REQ_PUT, int'(CH_RETURN), 0, 0, 0);
        push_req(REQ_PUT, int'(CH_BACKSPACE), 0, 0, 0);
        // tab past the line end moves to the next row
        push_req(REQ_SET, 0, 0, 75, 3);
        push_req(REQ_PUT, int'(CH_TAB), 0, 0, 0);
        // clamped set, then a printable in the corner wraps and scrolls
        push_req(REQ_SET, 0, 0, 127, 127);
        push_req(REQ_PUT, 'h5A, 'h4E, 0, 0);
        push_req(REQ_READ, 0, 0, 79, 23);
        push_req(REQ_PUT, int'(CH_NEWLINE), 0, 0, 0);
        push_req(REQ_READ, 0, 0, 79, 22);
        // blank the cell under the cursor
        push_req(REQ_SET, 0, 0, 1, 0);
        push_req(REQ_BLANK, 0, 0, 0, 0);
        push_req(REQ_READ, 0, 0, 1, 0);
        // undecoded codes
        push_req(REQ_UNUSED_LO, 255, 255, -1, -1);
        push_req(REQ_UNUSED_HI, 0, 0, 0, 0);
        // clear after the pipe has emptied
        push_req(REQ_CLEAR, 0, 0, 0, 0, 1'b1);
        push_req(REQ_READ, 0, 0, 79, 22);

        build_random(RANDOM_REQS);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reqs.size() > 0 || i_in_valid) @(posedge i_clk);
        while (awaited_reports.size() > 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        $display("%0d requests: put %0d, read %0d, set %0d, blank %0d, clear %0d, other %0d",
                 accepted_total, req_tally[REQ_PUT], req_tally[REQ_READ], req_tally[REQ_SET],
                 req_tally[REQ_BLANK], req_tally[REQ_CLEAR],
                 req_tally[REQ_UNUSED_LO] + req_tally[REQ_UNUSED_LO + 3'd1] +
                 req_tally[REQ_UNUSED_HI]);
        $display("%0d scrolls, %0d results checked, %0d mismatches, %0d cycles",
                 scroll_tally, checked_count, mismatch_count, cycle_count);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/tcce_pkg.sv
rtl/tcce_ram.sv
rtl/tcce_ctrl.sv
rtl/tcce_dp.sv
rtl/text_console_cursor_engine.sv
test/text_console_cursor_engine_test.sv
